[hdl/lsclip_pkg.sv]
`timescale 1ns / 1ps

package lsclip_pkg;

  localparam int COORD_WIDTH   = 16;
  localparam int FRACTION_BITS = 16;

  // A coordinate difference needs one bit more than a coordinate.
  localparam int DIFF_WIDTH    = COORD_WIDTH + 1;
  localparam int REM_WIDTH     = COORD_WIDTH + 2;
  localparam int QUO_WIDTH     = FRACTION_BITS + 1;
  localparam int DIV_STAGES    = FRACTION_BITS + 1;
  localparam int MAG_WIDTH     = FRACTION_BITS + 2;
  localparam int R_WIDTH       = FRACTION_BITS + 3;
  localparam int U_WIDTH       = FRACTION_BITS + 1;
  localparam int PROD_WIDTH    = FRACTION_BITS + COORD_WIDTH + 3;
  localparam int PIPE_LAT      = DIV_STAGES + 4;
  localparam int CFG_IDX_WIDTH = 2;
  localparam int LANES         = 4;

  localparam logic [MAG_WIDTH-1:0] U_CLAMP = MAG_WIDTH'((1 << FRACTION_BITS) + 1);
  localparam logic signed [R_WIDTH-1:0] U_ONE = R_WIDTH'(1 << FRACTION_BITS);

  localparam logic signed [COORD_WIDTH-1:0] RST_MIN = COORD_WIDTH'(100);
  localparam logic signed [COORD_WIDTH-1:0] RST_MAX = COORD_WIDTH'(200);

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_X_MIN = 2'd0,
    REG_Y_MIN = 2'd1,
    REG_X_MAX = 2'd2,
    REG_Y_MAX = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
  } in_t;

  typedef struct packed {
    logic                          accepted;
    logic signed [COORD_WIDTH-1:0] clipped_start_x;
    logic signed [COORD_WIDTH-1:0] clipped_start_y;
    logic signed [COORD_WIDTH-1:0] clipped_end_x;
    logic signed [COORD_WIDTH-1:0] clipped_end_y;
  } out_t;

  typedef struct packed {
    logic [DIFF_WIDTH-1:0] num;
    logic [DIFF_WIDTH-1:0] den;
  } div_in_t;

  typedef struct packed {
    logic [QUO_WIDTH-1:0] quo;
    logic                 ovf;
  } div_out_t;

  typedef struct packed {
    logic skip;
    logic prej;
    logic pneg;
    logic rneg;
  } lane_flag_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] sx;
    logic signed [COORD_WIDTH-1:0] sy;
    logic signed [DIFF_WIDTH-1:0]  dx;
    logic signed [DIFF_WIDTH-1:0]  dy;
  } side_t;

endpackage

[hdl/line_segment_window_clipper.sv]
`timescale 1ns / 1ps

// Liang-Barsky clipper for one segment against the window in four registers.
// Input: drive in_item with the two endpoints and raise start; the item is
// taken at any clock edge with start high and busy low. busy never rises, so a
// new segment may be given in every cycle.
// Output: out_valid is high for exactly one cycle with out_item holding the
// accept flag and the clipped endpoints (all zero when rejected). The receiver
// cannot hold results off, and none is needed: the pipeline never stalls.
// Pipeline: 21 register stages lie between the item and its result on the
// ports. They are the 17-stage quotient divider, one bit per stage, plus
// entry, combine, multiply and output stages.
// Throughput is one segment per cycle.
// Configuration: cfg_we writes cfg_wdata to window register cfg_index
// (x_min, y_min, x_max, y_max) at the clock edge; write only while idle.
// Reset: synchronous on rst_n low; the window returns to 100..200 on both
// axes and all in-flight items are dropped.
module line_segment_window_clipper import lsclip_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  in_t                      in_item,
  output logic                     out_valid,
  output out_t                     out_item,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]   cfg_wdata
);

  logic signed [COORD_WIDTH-1:0] x_min_r, y_min_r, x_max_r, y_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r <= RST_MIN;
      y_min_r <= RST_MIN;
      x_max_r <= RST_MAX;
      y_max_r <= RST_MAX;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_X_MIN: x_min_r <= cfg_wdata;
        REG_Y_MIN: y_min_r <= cfg_wdata;
        REG_X_MAX: x_max_r <= cfg_wdata;
        REG_Y_MAX: y_max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic in_acc;
  assign in_acc = start && !busy;

  // Entry stage: edge terms p and q, their magnitudes and signs.
  logic signed [DIFF_WIDTH-1:0] dx_c, dy_c;
  logic signed [DIFF_WIDTH-1:0] p_c [LANES];
  logic signed [DIFF_WIDTH-1:0] q_c [LANES];
  div_in_t    din_nxt [LANES];
  lane_flag_t flg_nxt [LANES];

  always_comb begin
    dx_c = DIFF_WIDTH'(in_item.end_x) - DIFF_WIDTH'(in_item.start_x);
    dy_c = DIFF_WIDTH'(in_item.end_y) - DIFF_WIDTH'(in_item.start_y);
    p_c[0] = -dx_c;
    p_c[1] = dx_c;
    p_c[2] = -dy_c;
    p_c[3] = dy_c;
    q_c[0] = DIFF_WIDTH'(in_item.start_x) - DIFF_WIDTH'(x_min_r);
    q_c[1] = DIFF_WIDTH'(x_max_r) - DIFF_WIDTH'(in_item.start_x);
    q_c[2] = DIFF_WIDTH'(in_item.start_y) - DIFF_WIDTH'(y_min_r);
    q_c[3] = DIFF_WIDTH'(y_max_r) - DIFF_WIDTH'(in_item.start_y);
    for (int l = 0; l < LANES; l++) begin
      din_nxt[l].num = q_c[l][DIFF_WIDTH-1] ? -q_c[l] : q_c[l];
      din_nxt[l].den = p_c[l][DIFF_WIDTH-1] ? -p_c[l] : p_c[l];
      flg_nxt[l].skip = p_c[l] == '0;
      flg_nxt[l].prej = (p_c[l] == '0) && q_c[l][DIFF_WIDTH-1];
      flg_nxt[l].pneg = p_c[l][DIFF_WIDTH-1];
      flg_nxt[l].rneg = p_c[l][DIFF_WIDTH-1] ^ q_c[l][DIFF_WIDTH-1];
    end
  end

  div_in_t    din_r [LANES];
  lane_flag_t flg_r [LANES];
  side_t      side_r;
  logic       v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    din_r     <= din_nxt;
    flg_r     <= flg_nxt;
    side_r.sx <= in_item.start_x;
    side_r.sy <= in_item.start_y;
    side_r.dx <= dx_c;
    side_r.dy <= dy_c;
  end

  div_out_t dout [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    lsclip_div u_div (
      .clk  (clk),
      .din  (din_r[l]),
      .dout (dout[l])
    );
  end

  // Side data follows the divider stages.
  logic [DIV_STAGES-1:0] vd_r;
  lane_flag_t            fd_r [DIV_STAGES][LANES];
  side_t                 sd_r [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= '0;
    end else begin
      vd_r <= {vd_r[DIV_STAGES-2:0], v1_r};
    end
  end

  always_ff @(posedge clk) begin
    fd_r[0] <= flg_r;
    sd_r[0] <= side_r;
    for (int k = 1; k < DIV_STAGES; k++) begin
      fd_r[k] <= fd_r[k-1];
      sd_r[k] <= sd_r[k-1];
    end
  end

  // Combine stage. Quotients are clamped to -1 lsb .. 1.0 + 1 lsb, which keeps
  // every comparison that can change the outcome.
  logic [MAG_WIDTH-1:0]       mag_c [LANES];
  logic signed [R_WIDTH-1:0]  r_c   [LANES];
  logic signed [R_WIDTH-1:0]  uin_c, uout_c;
  logic                       rej_c;

  always_comb begin
    uin_c  = '0;
    uout_c = U_ONE;
    rej_c  = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      if (dout[l].ovf || ({1'b0, dout[l].quo} > U_CLAMP)) begin
        mag_c[l] = U_CLAMP;
      end else begin
        mag_c[l] = {1'b0, dout[l].quo};
      end
      if (fd_r[DIV_STAGES-1][l].rneg) begin
        r_c[l] = (mag_c[l] == '0) ? '0 : -R_WIDTH'(1);
      end else begin
        r_c[l] = $signed({1'b0, mag_c[l]});
      end
      if (fd_r[DIV_STAGES-1][l].prej) begin
        rej_c = 1'b1;
      end
      if (!fd_r[DIV_STAGES-1][l].skip) begin
        if (fd_r[DIV_STAGES-1][l].pneg) begin
          if (r_c[l] > uin_c) begin
            uin_c = r_c[l];
          end
        end else begin
          if (r_c[l] < uout_c) begin
            uout_c = r_c[l];
          end
        end
      end
    end
    if (uin_c > uout_c) begin
      rej_c = 1'b1;
    end
  end

  logic                 cmb_v_r;
  logic                 cmb_acc_r;
  logic [U_WIDTH-1:0]   cmb_uin_r, cmb_uout_r;
  side_t                cmb_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmb_v_r <= 1'b0;
    end else begin
      cmb_v_r <= vd_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    cmb_acc_r  <= !rej_c;
    cmb_uin_r  <= uin_c[U_WIDTH-1:0];
    cmb_uout_r <= uout_c[U_WIDTH-1:0];
    cmb_side_r <= sd_r[DIV_STAGES-1];
  end

  // Multiply stage.
  logic                         mul_v_r;
  logic                         mul_acc_r;
  logic signed [PROD_WIDTH-1:0] pr_sx_r, pr_sy_r, pr_ex_r, pr_ey_r;
  logic signed [COORD_WIDTH-1:0] mul_sx_r, mul_sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
    end else begin
      mul_v_r <= cmb_v_r;
    end
  end

  always_ff @(posedge clk) begin
    mul_acc_r <= cmb_acc_r;
    mul_sx_r  <= cmb_side_r.sx;
    mul_sy_r  <= cmb_side_r.sy;
    pr_sx_r   <= PROD_WIDTH'($signed({1'b0, cmb_uin_r}) * cmb_side_r.dx);
    pr_sy_r   <= PROD_WIDTH'($signed({1'b0, cmb_uin_r}) * cmb_side_r.dy);
    pr_ex_r   <= PROD_WIDTH'($signed({1'b0, cmb_uout_r}) * cmb_side_r.dx);
    pr_ey_r   <= PROD_WIDTH'($signed({1'b0, cmb_uout_r}) * cmb_side_r.dy);
  end

  // Output stage: floor shift, offset from the start point.
  out_t out_nxt;
  logic signed [PROD_WIDTH-1:0] sh_sx, sh_sy, sh_ex, sh_ey;

  always_comb begin
    sh_sx = pr_sx_r >>> FRACTION_BITS;
    sh_sy = pr_sy_r >>> FRACTION_BITS;
    sh_ex = pr_ex_r >>> FRACTION_BITS;
    sh_ey = pr_ey_r >>> FRACTION_BITS;
    out_nxt = '0;
    if (mul_acc_r) begin
      out_nxt.accepted        = 1'b1;
      out_nxt.clipped_start_x = mul_sx_r + sh_sx[COORD_WIDTH-1:0];
      out_nxt.clipped_start_y = mul_sy_r + sh_sy[COORD_WIDTH-1:0];
      out_nxt.clipped_end_x   = mul_sx_r + sh_ex[COORD_WIDTH-1:0];
      out_nxt.clipped_end_y   = mul_sy_r + sh_ey[COORD_WIDTH-1:0];
    end
  end

  logic out_valid_r;
  out_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= mul_v_r;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_acc, PIPE_LAT))
    else $error("result without a matching input item");

  a_rej_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.accepted) |->
      (out_item.clipped_start_x == '0 && out_item.clipped_start_y == '0 &&
       out_item.clipped_end_x == '0 && out_item.clipped_end_y == '0))
    else $error("rejected segment with nonzero points");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cmb_v_r && cmb_acc_r) |-> (cmb_uin_r <= cmb_uout_r))
    else $error("accepted segment with entry past exit");

endmodule

[hdl/lsclip_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage. Computes (num << FRACTION_BITS) / den
// for the low QUO_WIDTH quotient bits and flags a quotient too large for them.
module lsclip_div import lsclip_pkg::*; (
  input  logic     clk,
  input  div_in_t  din,
  output div_out_t dout
);

  logic [REM_WIDTH-1:0]  rem_r [DIV_STAGES];
  logic [QUO_WIDTH-1:0]  quo_r [DIV_STAGES];
  logic [DIFF_WIDTH-1:0] den_r [DIV_STAGES];
  logic                  ovf_r [DIV_STAGES];

  logic [REM_WIDTH-1:0]  rem_nxt [DIV_STAGES];
  logic [QUO_WIDTH-1:0]  quo_nxt [DIV_STAGES];
  logic                  ovf_nxt;

  // The quotient fits in QUO_WIDTH bits exactly when num < 2 * den.
  assign ovf_nxt = {1'b0, din.num} >= {din.den, 1'b0};

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [REM_WIDTH-1:0] shifted;
    logic                 ge;
    if (k == 0) begin : g_first
      // Only the lowest dividend bit still lies above the fraction bits.
      assign shifted = REM_WIDTH'(din.num);
      assign ge      = shifted >= REM_WIDTH'(din.den);
      assign rem_nxt[k] = ge ? shifted - REM_WIDTH'(din.den) : shifted;
      assign quo_nxt[k] = QUO_WIDTH'(ge);
      always_ff @(posedge clk) begin
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= quo_nxt[k];
        den_r[k] <= din.den;
        ovf_r[k] <= ovf_nxt;
      end
    end else begin : g_rest
      assign shifted = {rem_r[k-1][REM_WIDTH-2:0], 1'b0};
      assign ge      = shifted >= REM_WIDTH'(den_r[k-1]);
      assign rem_nxt[k] = ge ? shifted - REM_WIDTH'(den_r[k-1]) : shifted;
      assign quo_nxt[k] = {quo_r[k-1][QUO_WIDTH-2:0], ge};
      always_ff @(posedge clk) begin
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= quo_nxt[k];
        den_r[k] <= den_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  assign dout.quo = quo_r[DIV_STAGES-1];
  assign dout.ovf = ovf_r[DIV_STAGES-1];

endmodule

[verif/tb_line_segment_window_clipper.sv]
`timescale 1ns / 1ps

module tb_line_segment_window_clipper;
  import lsclip_pkg::*;

  localparam int LATENCY   = PIPE_LAT + 1;
  localparam int WDOG_MAX  = 2000;

  // Holds the clip window and the queue of clipped segments still owed by the block.
  class clip_scoreboard;
    logic signed [COORD_WIDTH-1:0] win_x_min, win_y_min, win_x_max, win_y_max;
    out_t pending[$];
    int   errors;
    int   checked;
    int   accepted_cnt;

    function void reset_window();
      win_x_min = 100;
      win_y_min = 100;
      win_x_max = 200;
      win_y_max = 200;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [COORD_WIDTH-1:0] val);
      case (idx)
        REG_X_MIN: win_x_min = val;
        REG_Y_MIN: win_y_min = val;
        REG_X_MAX: win_x_max = val;
        REG_Y_MAX: win_y_max = val;
        default: ;
      endcase
    endfunction

    // Floor division by 2^FRACTION_BITS.
    function longint floor_frac(longint v);
      return v >>> FRACTION_BITS;
    endfunction

    function out_t clip_segment(in_t s);
      longint sx, sy, dx, dy, r, u_in, u_out;
      longint p[4];
      longint q[4];
      bit     reject;
      out_t   o;
      sx = s.start_x;
      sy = s.start_y;
      dx = longint'(s.end_x) - sx;
      dy = longint'(s.end_y) - sy;
      p[0] = -dx; p[1] = dx; p[2] = -dy; p[3] = dy;
      q[0] = sx - win_x_min;
      q[1] = longint'(win_x_max) - sx;
      q[2] = sy - win_y_min;
      q[3] = longint'(win_y_max) - sy;
      u_in = 0;
      u_out = longint'(1) << FRACTION_BITS;
      reject = 0;
      for (int i = 0; i < 4; i++) begin
        if (p[i] == 0) begin
          if (q[i] < 0) reject = 1;
        end else begin
          // SystemVerilog signed division truncates toward zero.
          r = (q[i] * (longint'(1) << FRACTION_BITS)) / p[i];
          if (p[i] < 0) begin
            if (r > u_in) u_in = r;
          end else if (r < u_out) begin
            u_out = r;
          end
        end
      end
      if (u_in > u_out) reject = 1;
      o = '0;
      if (!reject) begin
        o.accepted        = 1'b1;
        o.clipped_start_x = COORD_WIDTH'(sx + floor_frac(u_in * dx));
        o.clipped_start_y = COORD_WIDTH'(sy + floor_frac(u_in * dy));
        o.clipped_end_x   = COORD_WIDTH'(sx + floor_frac(u_out * dx));
        o.clipped_end_y   = COORD_WIDTH'(sy + floor_frac(u_out * dy));
      end
      return o;
    endfunction

    function void note_segment(in_t s);
      pending.push_back(clip_segment(s));
    endfunction

    function void check_result(out_t got);
      out_t exp_o;
      if (pending.size() == 0) begin
        $error("result with no segment outstanding: %h", got);
        errors++;
        return;
      end
      exp_o = pending.pop_front();
      checked++;
      if (got.accepted) accepted_cnt++;
      if (got.accepted !== exp_o.accepted) begin
        $error("accepted: expected %0d, got %0d", exp_o.accepted, got.accepted);
        errors++;
      end
      if (got.clipped_start_x !== exp_o.clipped_start_x) begin
        $error("clipped_start_x: expected %0d, got %0d",
               exp_o.clipped_start_x, got.clipped_start_x);
        errors++;
      end
      if (got.clipped_start_y !== exp_o.clipped_start_y) begin
        $error("clipped_start_y: expected %0d, got %0d",
               exp_o.clipped_start_y, got.clipped_start_y);
        errors++;
      end
      if (got.clipped_end_x !== exp_o.clipped_end_x) begin
        $error("clipped_end_x: expected %0d, got %0d",
               exp_o.clipped_end_x, got.clipped_end_x);
        errors++;
      end
      if (got.clipped_end_y !== exp_o.clipped_end_y) begin
        $error("clipped_end_y: expected %0d, got %0d",
               exp_o.clipped_end_y, got.clipped_end_y);
        errors++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  in_t                      in_item;
  logic                     out_valid;
  out_t                     out_item;
  logic                     cfg_we;
  logic [CFG_IDX_WIDTH-1:0] cfg_index;
  logic [COORD_WIDTH-1:0]   cfg_wdata;

  clip_scoreboard sb;
  int  idle_cycles;
  int  segments_sent;
  int  window_writes;

  line_segment_window_clipper DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_item);
  end

  // Watchdog: counts cycles in which neither an item nor a result moved.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_window(cfg_reg_t idx, logic [COORD_WIDTH-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    window_writes++;
  endtask

  task automatic set_window(int xmin, int ymin, int xmax, int ymax);
    drain();
    write_window(REG_X_MIN, COORD_WIDTH'(xmin));
    write_window(REG_Y_MIN, COORD_WIDTH'(ymin));
    write_window(REG_X_MAX, COORD_WIDTH'(xmax));
    write_window(REG_Y_MAX, COORD_WIDTH'(ymax));
    cfg_we <= 1'b0;
  endtask

  // Presents one segment; keeps start high so that back-to-back items stream.
  task automatic send_segment(int sx, int sy, int ex, int ey);
    in_t s;
    s.start_x = COORD_WIDTH'(sx);
    s.start_y = COORD_WIDTH'(sy);
    s.end_x   = COORD_WIDTH'(ex);
    s.end_y   = COORD_WIDTH'(ey);
    start   <= 1'b1;
    in_item <= s;
    do @(posedge clk); while (busy);
    sb.note_segment(s);
    segments_sent++;
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic int rand_coord(int lo, int hi);
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32767 : -32768;
      1: return $signed(16'($urandom()));
      default: return lo + int'($urandom_range(0, hi - lo));
    endcase
  endfunction

  task automatic random_burst(int count, int lo, int hi);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 20);
      if (burst > left) burst = left;
      for (int k = 0; k < burst; k++)
        send_segment(rand_coord(lo, hi), rand_coord(lo, hi),
                     rand_coord(lo, hi), rand_coord(lo, hi));
      left -= burst;
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 12));
    end
    start <= 1'b0;
  endtask

  initial begin
    sb = new();
    sb.reset_window();
    rst_n = 0; start = 0; in_item = '0; cfg_we = 0; cfg_index = '0; cfg_wdata = '0;
    segments_sent = 0; window_writes = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset window, inside, crossing, outside, points, parallel edges.
    send_segment(150, 150, 160, 170);
    send_segment(0, 150, 300, 150);
    send_segment(150, 0, 150, 300);
    send_segment(0, 0, 300, 300);
    send_segment(300, 300, 0, 0);
    send_segment(0, 0, 50, 50);
    send_segment(150, 150, 150, 150);
    send_segment(50, 150, 50, 150);
    send_segment(50, 0, 50, 300);
    send_segment(0, 250, 300, 250);
    send_segment(-32768, -32768, 32767, 32767);
    send_segment(32767, -32768, -32768, 32767);
    send_segment(100, 100, 200, 200);
    send_segment(99, 250, 250, 99);
    pause(3);
    set_window(-32768, -32768, 32767, 32767);
    send_segment(-32768, 32767, 32767, -32768);
    send_segment(-32768, -32768, -32768, -32768);
    send_segment(32767, 32767, 0, 0);
    pause(2);
    // Inverted window.
    set_window(200, 200, 100, 100);
    send_segment(0, 0, 300, 300);
    send_segment(150, 150, 150, 150);
    send_segment(150, 0, 150, 300);
    pause(1);

    // Random phases over several windows, extremes among them.
    set_window(100, 100, 200, 200);
    random_burst(160, 0, 300);
    set_window(-1000, -500, 1000, 500);
    random_burst(160, -2000, 2000);
    set_window(-32768, -32768, 32767, 32767);
    random_burst(100, -32768, 32767);
    set_window(0, 0, 0, 0);
    random_burst(60, -4, 4);
    set_window(32767, -32768, 32767, -32768);
    random_burst(60, -32768, 32767);
    set_window($signed(16'($urandom())), $signed(16'($urandom())),
               $signed(16'($urandom())), $signed(16'($urandom())));
    random_burst(60, -32768, 32767);

    drain();
    $display("Sent %0d segments over %0d window writes; %0d results checked, %0d accepted.",
             segments_sent, window_writes, sb.checked, sb.accepted_cnt);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
